// ===== rtl/core/block_average_decimator_unit_assert.svh =====
// ----------------------------------------------------------------------------
// block_average_decimator_unit assertion macros
// Concurrent assertion shorthands used by the decimator unit RTL.
// ----------------------------------------------------------------------------
`ifndef BLOCK_AVERAGE_DECIMATOR_UNIT_ASSERT_SVH
`define BLOCK_AVERAGE_DECIMATOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define BAD_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bad assertion failed: same-cycle implication");

// Next-cycle implication, checked out of reset
`define BAD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bad assertion failed: next-cycle implication");

`endif

// ===== rtl/core/bad_pkg.sv =====
// ----------------------------------------------------------------------------
// bad_pkg
// Shared constants and types for the block average decimator.
// ----------------------------------------------------------------------------
package bad_pkg;

    // Default parameter values
    localparam int DEF_MAX_FACTOR  = 256;
    localparam int DEF_SAMPLE_BITS = 24;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_FACTOR   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_CAPACITY = 2'd1;

    // Register widths and reset values
    localparam int FACTOR_W = 9;
    localparam int COUNT_W  = 16;

    localparam logic [FACTOR_W-1:0] FACTOR_RESET   = 9'd1;
    localparam logic [COUNT_W-1:0]  CAPACITY_RESET = 16'hFFFF;

    // Result kinds
    localparam logic KIND_AVERAGE = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    // Divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } bad_div_status_t;

endpackage

// ===== rtl/core/bad_divider.sv =====
// ----------------------------------------------------------------------------
// bad_divider
// Serial restoring divider: signed dividend by unsigned divisor, quotient
// truncated toward zero. One quotient bit per cycle, then a sign fix step.
// ----------------------------------------------------------------------------
module bad_divider
    import bad_pkg::*;
#(
    parameter int SUM_W = 33,
    parameter int DIV_W = 9,
    parameter int OUT_W = 24
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [SUM_W-1:0]      dividend,
    input  logic [DIV_W-1:0]      divisor,
    output bad_div_status_t       status,
    output logic [OUT_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(SUM_W + 1);

    logic [SUM_W-1:0] quo_reg, quo_next;
    logic [DIV_W-1:0] rem_reg, rem_next;
    logic [DIV_W-1:0] divisor_reg, divisor_next;
    logic             neg_reg, neg_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [OUT_W-1:0] result_reg, result_next;

    logic [DIV_W:0]   trial;
    logic             fits;
    logic [DIV_W:0]   trial_diff;
    logic [SUM_W-1:0] quo_signed;

    // Shift-subtract step
    assign trial      = {rem_reg, quo_reg[SUM_W-1]};
    assign fits       = trial >= {1'b0, divisor_reg};
    assign trial_diff = trial - {1'b0, divisor_reg};
    assign quo_signed = neg_reg ? (~quo_reg + {{(SUM_W-1){1'b0}}, 1'b1}) : quo_reg;

    always_comb begin
        quo_next     = quo_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        neg_next     = neg_reg;
        cnt_next     = cnt_reg;
        busy_next    = busy_reg;
        done_next    = 1'b0;
        result_next  = result_reg;
        if (start) begin
            // Load magnitude and sign
            neg_next     = dividend[SUM_W-1];
            quo_next     = dividend[SUM_W-1]
                           ? (~dividend + {{(SUM_W-1){1'b0}}, 1'b1}) : dividend;
            rem_next     = '0;
            divisor_next = divisor;
            cnt_next     = CNT_W'(SUM_W);
            busy_next    = 1'b1;
        end else if (busy_reg) begin
            if (cnt_reg != '0) begin
                rem_next = fits ? trial_diff[DIV_W-1:0] : trial[DIV_W-1:0];
                quo_next = {quo_reg[SUM_W-2:0], fits};
                cnt_next = cnt_reg - CNT_W'(1);
            end else begin
                // Sign fix and result latch
                result_next = quo_signed[OUT_W-1:0];
                busy_next   = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg     <= quo_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
        neg_reg     <= neg_next;
        result_reg  <= result_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = result_reg;

endmodule

// ===== rtl/core/block_average_decimator_unit.sv =====
// Flow: a sample that closes no group is added to the running sum. One that closes a
// group below capacity runs SAMPLE_BITS + POS_W (9 at the defaults) quotient steps
// and a sign fix step in the serial divider, then its average request goes out; a
// block end puts the summary request out after it, or alone. Throughput: one sample
// per cycle between group ends and block ends; no sample is taken until the average
// and summary are out. Reset: synchronous, active low; factor 1, capacity 65535.
// ----------------------------------------------------------------------------
// block_average_decimator_unit
// Boxcar average and decimate: sums each group of samples and divides by the
// group size with a shared serial divider, and emits a summary at each block end.
// ----------------------------------------------------------------------------
module block_average_decimator_unit
    import bad_pkg::*;
#(
    parameter int MAX_FACTOR  = DEF_MAX_FACTOR,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    // Configuration writes
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    // Sample requests
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [SAMPLE_BITS-1:0] s_sample,
    input  logic                   s_block_end,
    // Result requests
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_kind,
    output logic [SAMPLE_BITS-1:0] m_average,
    output logic [COUNT_W-1:0]     m_output_count,
    output logic                   m_too_short,
    output logic                   m_final_res
);

    `include "block_average_decimator_unit_assert.svh"

    // Largest factor reachable through the register
    localparam int FACT_REG_MAX = (1 << FACTOR_W) - 1;
    localparam int FACT_LIM     = (MAX_FACTOR < FACT_REG_MAX) ? MAX_FACTOR : FACT_REG_MAX;
    localparam int POS_W        = $clog2(FACT_LIM + 1);
    localparam int SUM_W        = SAMPLE_BITS + POS_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_AVERAGE,
        ST_SUMMARY
    } state_t;

    state_t                 state_reg, state_next;
    logic [FACTOR_W-1:0]    factor_reg, factor_next;
    logic [COUNT_W-1:0]     capacity_reg, capacity_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic [COUNT_W-1:0]     emitted_reg, emitted_next;
    logic                   last_pend_reg, last_pend_next;

    logic                   m_valid_reg, m_valid_next;
    logic                   m_kind_reg, m_kind_next;
    logic [SAMPLE_BITS-1:0] m_average_reg, m_average_next;
    logic [COUNT_W-1:0]     m_output_count_reg, m_output_count_next;
    logic                   m_too_short_reg, m_too_short_next;
    logic                   m_final_res_reg, m_final_res_next;

    logic [POS_W-1:0]       eff_factor;
    logic [COUNT_W-1:0]     eff_capacity;
    logic [SUM_W-1:0]       sum_acc;
    logic [POS_W-1:0]       pos_inc;
    logic                   group_done;
    logic                   cap_ok;
    logic                   out_free;
    logic                   div_start;
    bad_div_status_t        div_status;
    logic [SAMPLE_BITS-1:0] div_quotient;

    // Effective factor and capacity
    always_comb begin
        if (factor_reg == '0) begin
            eff_factor = POS_W'(1);
        end else if (factor_reg > FACTOR_W'(FACT_LIM)) begin
            eff_factor = POS_W'(FACT_LIM);
        end else begin
            eff_factor = factor_reg[POS_W-1:0];
        end
    end

    assign eff_capacity = (capacity_reg == '0) ? COUNT_W'(1) : capacity_reg;

    // Accumulate and group-close detect
    assign sum_acc    = sum_reg + {{(SUM_W-SAMPLE_BITS){s_sample[SAMPLE_BITS-1]}}, s_sample};
    assign pos_inc    = pos_reg + POS_W'(1);
    assign group_done = pos_inc >= eff_factor;
    assign cap_ok     = emitted_reg < eff_capacity;
    assign out_free   = !m_valid_reg || m_ready;

    // Configuration decode
    always_comb begin
        factor_next   = factor_reg;
        capacity_next = capacity_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_IDX_FACTOR:   factor_next   = cfg_data[FACTOR_W-1:0];
                CFG_IDX_CAPACITY: capacity_next = cfg_data[COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequencer
    always_comb begin
        state_next          = state_reg;
        sum_next            = sum_reg;
        pos_next            = pos_reg;
        emitted_next        = emitted_reg;
        last_pend_next      = last_pend_reg;
        div_start           = 1'b0;
        m_valid_next        = m_valid_reg && !m_ready;
        m_kind_next         = m_kind_reg;
        m_average_next      = m_average_reg;
        m_output_count_next = m_output_count_reg;
        m_too_short_next    = m_too_short_reg;
        m_final_res_next    = m_final_res_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (group_done) begin
                        sum_next = '0;
                        pos_next = '0;
                        if (cap_ok) begin
                            div_start    = 1'b1;
                            emitted_next = emitted_reg + COUNT_W'(1);
                        end
                    end else begin
                        sum_next = sum_acc;
                        pos_next = pos_inc;
                    end
                    if (s_block_end) begin
                        sum_next       = '0;
                        pos_next       = '0;
                        last_pend_next = 1'b1;
                    end
                    if (group_done && cap_ok) begin
                        state_next = ST_DIV;
                    end else if (s_block_end) begin
                        state_next = ST_SUMMARY;
                    end
                end
            end
            ST_DIV: begin
                if (div_status.done) begin
                    state_next = ST_AVERAGE;
                end
            end
            ST_AVERAGE: begin
                if (out_free) begin
                    m_valid_next        = 1'b1;
                    m_kind_next         = KIND_AVERAGE;
                    m_average_next      = div_quotient;
                    m_output_count_next = '0;
                    m_too_short_next    = 1'b0;
                    m_final_res_next    = 1'b0;
                    state_next          = last_pend_reg ? ST_SUMMARY : ST_IDLE;
                end
            end
            ST_SUMMARY: begin
                if (out_free) begin
                    m_valid_next        = 1'b1;
                    m_kind_next         = KIND_SUMMARY;
                    m_average_next      = '0;
                    m_output_count_next = emitted_reg;
                    m_too_short_next    = (emitted_reg == '0);
                    m_final_res_next    = 1'b1;
                    emitted_next        = '0;
                    last_pend_next      = 1'b0;
                    state_next          = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State, config and output registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            factor_reg    <= FACTOR_RESET;
            capacity_reg  <= CAPACITY_RESET;
            sum_reg       <= '0;
            pos_reg       <= '0;
            emitted_reg   <= '0;
            last_pend_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            factor_reg    <= factor_next;
            capacity_reg  <= capacity_next;
            sum_reg       <= sum_next;
            pos_reg       <= pos_next;
            emitted_reg   <= emitted_next;
            last_pend_reg <= last_pend_next;
            m_valid_reg   <= m_valid_next;
        end
        m_kind_reg         <= m_kind_next;
        m_average_reg      <= m_average_next;
        m_output_count_reg <= m_output_count_next;
        m_too_short_reg    <= m_too_short_next;
        m_final_res_reg    <= m_final_res_next;
    end

    // Shared divider
    bad_divider #(
        .SUM_W (SUM_W),
        .DIV_W (POS_W),
        .OUT_W (SAMPLE_BITS)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_acc),
        .divisor  (eff_factor),
        .status   (div_status),
        .quotient (div_quotient)
    );

    assign cfg_ready      = 1'b1;
    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_kind         = m_kind_reg;
    assign m_average      = m_average_reg;
    assign m_output_count = m_output_count_reg;
    assign m_too_short    = m_too_short_reg;
    assign m_final_res    = m_final_res_reg;

    // Checks
    `BAD_ASSERT_SAME(a_summary_fields, aclk, aresetn, m_valid && (m_kind == KIND_SUMMARY), m_final_res && (m_average == '0))
    `BAD_ASSERT_SAME(a_average_fields, aclk, aresetn, m_valid && (m_kind == KIND_AVERAGE), !m_final_res && !m_too_short && (m_output_count == '0))
    `BAD_ASSERT_NEXT(a_block_end_busy, aclk, aresetn, s_valid && s_ready && s_block_end, !s_ready)
    `BAD_ASSERT_SAME(a_div_only_in_div, aclk, aresetn, div_status.busy, state_reg == ST_DIV)

endmodule
